FILE: src/tile_background_window_pixel_unit_macros.svh
// Assertion macros for the tile background and window pixel unit
`ifndef TILE_BACKGROUND_WINDOW_PIXEL_UNIT_MACROS_SVH
`define TILE_BACKGROUND_WINDOW_PIXEL_UNIT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define TBW_ASSERT_IMP(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("tbw assertion failed");
// Check that a condition implies a consequence in the next cycle
`define TBW_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("tbw assertion failed");
`endif

FILE: src/tbw_pkg.sv
// ----------------------------------------------------------------------------
// tbw_pkg
// Types and constants shared by the tile background and window pixel unit.
// ----------------------------------------------------------------------------
package tbw_pkg;

  localparam int VIDEO_BANKS = 2;
  localparam int PALETTE_BYTES = 64;

  localparam logic [1:0] OP_VRAM_WR = 2'd0;
  localparam logic [1:0] OP_PAL_WR  = 2'd1;
  localparam logic [1:0] OP_RENDER  = 2'd2;

  localparam logic [2:0] REG_LCDC = 3'd0;
  localparam logic [2:0] REG_SCY  = 3'd1;
  localparam logic [2:0] REG_SCX  = 3'd2;
  localparam logic [2:0] REG_WY   = 3'd3;
  localparam logic [2:0] REG_WX   = 3'd4;
  localparam logic [2:0] REG_BGP  = 3'd5;
  localparam logic [2:0] REG_CGB  = 3'd6;

  localparam logic [12:0] MAP_HI = 13'h1C00;
  localparam logic [12:0] MAP_LO = 13'h1800;
  localparam logic [12:0] SIGNED_BASE = 13'h0800;
  localparam logic [7:0] WX_MAX = 8'd166;
  localparam logic [7:0] WY_MAX = 8'd143;
  localparam logic [31:0] ALPHA = 32'hFF000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [31:0] argb;
    logic        drawn;
    logic        from_window;
  } out_res_t;

  function automatic logic [31:0] mono_shade(input logic [1:0] s);
    logic [31:0] r;
    begin
      unique case (s)
        2'd0: r = 32'hFFFFFFFF;
        2'd1: r = 32'hFF8BAC0F;
        2'd2: r = 32'hFF306230;
        default: r = 32'hFF0F380F;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: src/tile_background_window_pixel_unit.sv
// ----------------------------------------------------------------------------
// tile_background_window_pixel_unit
// Tile map background and window pixel renderer with video and palette RAM.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is a video byte write, a palette byte
// write or a pixel render. Renders give one result on the out_ channel; writes
// and unknown ops give none. Registers must be set over the cfg_ APB port
// only while the pipeline is empty; the block itself does not enforce this.
// Throughput: one request per cycle unless the output stalls; six register
// stages (address, map and attribute read, tile row address, plane read,
// palette read, output register). Each video bank is kept as even and odd
// byte arrays, so both planes of a tile row come from one address and no
// array sees more than two reads and one write.
// Reset loads the registers with their defaults and clears all valid bits;
// the memories hold no reset value and must be loaded before drawing.
// When the receiver stalls the whole pipeline holds; in_ready drops only while
// the output register is full and not taken.
// Video writes land at the plane read stage; a render reading its map entry
// while an older write to that byte is still in flight takes the write data,
// so every render sees all writes sent before it.
// ----------------------------------------------------------------------------
module tile_background_window_pixel_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tbw_pkg::in_req_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tbw_pkg::out_res_t     out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import tbw_pkg::*;

  // configuration
  logic [7:0] lcdc_r, scy_r, scx_r, wy_r, wx_r, bgp_r;
  logic       cgb_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r <= 8'd145; scy_r <= '0; scx_r <= '0; wy_r <= '0; wx_r <= '0;
      bgp_r <= 8'd252; cgb_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_idx)
        REG_LCDC: lcdc_r <= cfg_pwdata[7:0];
        REG_SCY:  scy_r  <= cfg_pwdata[7:0];
        REG_SCX:  scx_r  <= cfg_pwdata[7:0];
        REG_WY:   wy_r   <= cfg_pwdata[7:0];
        REG_WX:   wx_r   <= cfg_pwdata[7:0];
        REG_BGP:  bgp_r  <= cfg_pwdata[7:0];
        REG_CGB:  cgb_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_LCDC: cfg_prdata[7:0] = lcdc_r;
      REG_SCY:  cfg_prdata[7:0] = scy_r;
      REG_SCX:  cfg_prdata[7:0] = scx_r;
      REG_WY:   cfg_prdata[7:0] = wy_r;
      REG_WX:   cfg_prdata[7:0] = wx_r;
      REG_BGP:  cfg_prdata[7:0] = bgp_r;
      REG_CGB:  cfg_prdata[0]   = cgb_r;
      default:  cfg_prdata = '0;
    endcase
  end

  // memories: each video bank as even and odd byte arrays
  logic [7:0] vram0_ev [0:4095];
  logic [7:0] vram0_od [0:4095];
  logic [7:0] vram1_ev [0:4095];
  logic [7:0] vram1_od [0:4095];
  logic [7:0] pal_lo [0:PALETTE_BYTES/2-1];
  logic [7:0] pal_hi [0:PALETTE_BYTES/2-1];
  logic       attr_bank;

  assign attr_bank = (VIDEO_BANKS > 1);

  // pipeline advance
  logic adv;
  logic out_valid_r;
  logic in_acc;
  logic w1_r, pw1_r, r1_r, w2_r, pw2_r, r2_r, w3_r, pw3_r, r3_r, pw4_r, r4_r, r5_r;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc = in_valid && in_ready;

  // valid bits advance with the data and clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= 1'b0; pw1_r <= 1'b0; r1_r <= 1'b0;
      w2_r <= 1'b0; pw2_r <= 1'b0; r2_r <= 1'b0;
      w3_r <= 1'b0; pw3_r <= 1'b0; r3_r <= 1'b0;
      pw4_r <= 1'b0; r4_r <= 1'b0; r5_r <= 1'b0;
    end else if (adv) begin
      w1_r  <= in_acc && in_data.op == OP_VRAM_WR;
      pw1_r <= in_acc && in_data.op == OP_PAL_WR;
      r1_r  <= in_acc && in_data.op == OP_RENDER;
      w2_r <= w1_r; pw2_r <= pw1_r; r2_r <= r1_r;
      w3_r <= w2_r; pw3_r <= pw2_r; r3_r <= r2_r;
      pw4_r <= pw3_r; r4_r <= r3_r;
      r5_r <= r4_r;
    end
  end

  // stage 1: coordinates, window decision, map entry address
  logic        bgoff1_r, win1_r, drawn1_r;
  logic [13:0] a1_r;
  logic [7:0]  d1_r, px1_r, py1_r, lx1_r, ly1_r;
  logic [12:0] ent1_r;
  logic        win_hit;
  logic [8:0]  wxc;
  logic [7:0]  lx_c, ly_c;
  logic [12:0] map_c;

  always_comb begin
    wxc = {1'b0, in_data.pixel_x} + 9'd7;
    win_hit = lcdc_r[5] && (wx_r <= WX_MAX) && (wy_r <= WY_MAX) &&
              (in_data.pixel_y >= wy_r) && (wxc >= {1'b0, wx_r});
    if (win_hit) begin
      map_c = lcdc_r[6] ? MAP_HI : MAP_LO;
      ly_c = in_data.pixel_y - wy_r;
      lx_c = wxc[7:0] - wx_r;
    end else begin
      map_c = lcdc_r[3] ? MAP_HI : MAP_LO;
      ly_c = in_data.pixel_y + scy_r;
      lx_c = in_data.pixel_x + scx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= in_data.addr; d1_r <= in_data.wdata;
      px1_r <= in_data.pixel_x; py1_r <= in_data.pixel_y;
      drawn1_r <= lcdc_r[7];
      win1_r <= lcdc_r[7] && win_hit;
      bgoff1_r <= !win_hit && !lcdc_r[0] && !cgb_r;
      lx1_r <= lx_c; ly1_r <= ly_c;
      ent1_r <= map_c + {3'd0, ly_c[7:3], lx_c[7:3]};
    end
  end

  // stage 2: read tile number and attribute, take data of writes in flight
  logic        bgoff2_r, win2_r, drawn2_r;
  logic [13:0] a2_r, a3_r;
  logic [7:0]  d2_r, d3_r, px2_r, py2_r;
  logic [2:0]  row2_r, col2_r;
  logic        odd2_r, tfwd2_r, afwd2_r;
  logic [7:0]  tev2_r, tod2_r, aev2_r, aod2_r, tfd2_r, afd2_r;
  logic [7:0]  tile2, attr2;
  logic [13:0] tile_a, attr_a, wa2, wa3;
  logic        thit2, thit3, ahit2, ahit3;

  // compare the map byte addresses against writes not yet in memory
  always_comb begin
    tile_a = {1'b0, ent1_r};
    attr_a = {attr_bank, ent1_r};
    wa2 = {a2_r[13] && attr_bank, a2_r[12:0]};
    wa3 = {a3_r[13] && attr_bank, a3_r[12:0]};
    thit2 = w2_r && (wa2 == tile_a);
    thit3 = w3_r && (wa3 == tile_a);
    ahit2 = w2_r && (wa2 == attr_a);
    ahit3 = w3_r && (wa3 == attr_a);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r <= a1_r; d2_r <= d1_r; px2_r <= px1_r; py2_r <= py1_r;
      bgoff2_r <= bgoff1_r; win2_r <= win1_r; drawn2_r <= drawn1_r;
      row2_r <= ly1_r[2:0]; col2_r <= lx1_r[2:0];
      odd2_r <= ent1_r[0];
      tev2_r <= vram0_ev[ent1_r[12:1]];
      tod2_r <= vram0_od[ent1_r[12:1]];
      aev2_r <= attr_bank ? vram1_ev[ent1_r[12:1]] : vram0_ev[ent1_r[12:1]];
      aod2_r <= attr_bank ? vram1_od[ent1_r[12:1]] : vram0_od[ent1_r[12:1]];
      tfwd2_r <= thit2 || thit3;
      tfd2_r <= thit2 ? d2_r : d3_r;
      afwd2_r <= ahit2 || ahit3;
      afd2_r <= ahit2 ? d2_r : d3_r;
    end
  end

  // pick the byte, the younger write wins
  always_comb begin
    tile2 = tfwd2_r ? tfd2_r : (odd2_r ? tod2_r : tev2_r);
    if (!cgb_r) attr2 = 8'd0;
    else if (afwd2_r) attr2 = afd2_r;
    else attr2 = odd2_r ? aod2_r : aev2_r;
  end

  // stage 3: tile row word address
  logic        bgoff3_r, win3_r, drawn3_r, bank3_r, hflip3_r;
  logic [7:0]  px3_r, py3_r;
  logic [2:0]  col3_r, pal3_r;
  logic [11:0] da3_r;
  logic [11:0] dbase;
  logic [2:0]  rowf;

  always_comb begin
    dbase = lcdc_r[4] ? {1'b0, tile2, 3'd0}
                      : SIGNED_BASE[12:1] + {1'b0, tile2 ^ 8'h80, 3'd0};
    rowf = attr2[6] ? 3'd7 - row2_r : row2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_r <= a2_r; d3_r <= d2_r; px3_r <= px2_r; py3_r <= py2_r;
      bgoff3_r <= bgoff2_r; win3_r <= win2_r; drawn3_r <= drawn2_r;
      col3_r <= col2_r; pal3_r <= attr2[2:0];
      bank3_r <= attr2[3] && attr_bank;
      hflip3_r <= attr2[5];
      da3_r <= dbase + {9'd0, rowf};
    end
  end

  // stage 4: read both planes, perform video writes
  logic        bgoff4_r, win4_r, drawn4_r;
  logic [5:0]  a4_r;
  logic [7:0]  d4_r, px4_r, py4_r, lo4_r, hi4_r;
  logic [2:0]  bit4_r, pal4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r <= a3_r[5:0]; d4_r <= d3_r; px4_r <= px3_r; py4_r <= py3_r;
      bgoff4_r <= bgoff3_r; win4_r <= win3_r; drawn4_r <= drawn3_r;
      pal4_r <= pal3_r;
      bit4_r <= hflip3_r ? col3_r : 3'd7 - col3_r;
      lo4_r <= bank3_r ? vram1_ev[da3_r] : vram0_ev[da3_r];
      hi4_r <= bank3_r ? vram1_od[da3_r] : vram0_od[da3_r];
    end
  end

  // video writes go into the bank chosen by address bit 13
  always_ff @(posedge clk) begin
    if (adv && w3_r) begin
      if (a3_r[13] && attr_bank) begin
        if (a3_r[0]) vram1_od[a3_r[12:1]] <= d3_r;
        else vram1_ev[a3_r[12:1]] <= d3_r;
      end else begin
        if (a3_r[0]) vram0_od[a3_r[12:1]] <= d3_r;
        else vram0_ev[a3_r[12:1]] <= d3_r;
      end
    end
  end

  // stage 5: color id, palette read
  logic        bgoff5_r, win5_r, drawn5_r;
  logic [7:0]  px5_r, py5_r, plo5_r, phi5_r;
  logic [1:0]  cid5_r;
  logic [1:0]  cid;
  logic [4:0]  pidx;

  assign cid = {hi4_r[bit4_r], lo4_r[bit4_r]};
  assign pidx = {pal4_r, cid};

  always_ff @(posedge clk) begin
    if (adv) begin
      px5_r <= px4_r; py5_r <= py4_r;
      bgoff5_r <= bgoff4_r; win5_r <= win4_r; drawn5_r <= drawn4_r;
      cid5_r <= cid;
      plo5_r <= pal_lo[pidx];
      phi5_r <= pal_hi[pidx];
    end
  end

  // palette writes, split into even and odd bytes
  always_ff @(posedge clk) begin
    if (adv && pw4_r) begin
      if (a4_r[0]) pal_hi[a4_r[5:1]] <= d4_r;
      else pal_lo[a4_r[5:1]] <= d4_r;
    end
  end

  // stage 6: colour conversion into the output register
  logic [14:0] rgb;
  logic [31:0] argb_c;
  out_res_t    out_r;

  always_comb begin
    rgb = {phi5_r[6:0], plo5_r};
    if (!drawn5_r) argb_c = '0;
    else if (bgoff5_r) argb_c = mono_shade(2'd0);
    else if (cgb_r)
      argb_c = ALPHA | {8'd0, rgb[4:0], 3'd0, rgb[9:5], 3'd0, rgb[14:10], 3'd0};
    else argb_c = mono_shade(bgp_r[{cid5_r, 1'b0} +: 2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= r5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_x <= px5_r;
      out_r.out_y <= py5_r;
      out_r.argb <= argb_c;
      out_r.drawn <= drawn5_r;
      out_r.from_window <= win5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `include "tile_background_window_pixel_unit_macros.svh"

  `TBW_ASSERT_IMP(a_stall_blocks_input, out_valid_r && !out_ready, !in_ready)
  `TBW_ASSERT_IMP(a_undrawn_black, out_valid_r && !out_r.drawn, out_r.argb == 32'd0)
  `TBW_ASSERT_NEXT(a_hold_on_stall, out_valid_r && !out_ready, out_valid_r && $stable(out_r))

endmodule

FILE: verif/tile_background_window_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_window_pixel_checker
// Watches the request, result and register ports of the pixel unit, keeps a
// shadow of its video RAM, palette RAM and registers, predicts each rendered
// pixel and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tile_background_window_pixel_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tbw_pkg::in_req_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tbw_pkg::out_res_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 errors,
  output int                 pending
);
  import tbw_pkg::*;

  logic [7:0] vram_shadow [0:16383];
  logic [7:0] pal_shadow [0:63];
  logic [7:0] lcdc, scy, scx, wy, wx, bgp;
  logic       cgb;
  out_res_t   pixel_q [$];

  assign pending = pixel_q.size();

  function automatic logic [31:0] shade_of(input logic [1:0] s);
    logic [31:0] shades [4];
    shades = '{32'hFFFFFFFF, 32'hFF8BAC0F, 32'hFF306230, 32'hFF0F380F};
    return shades[s];
  endfunction

  // single-bank builds fold every bank select onto bank 0
  function automatic logic [7:0] vram_byte(input logic bank, input logic [12:0] off);
    logic b;
    b = (VIDEO_BANKS > 1) ? bank : 1'b0;
    return vram_shadow[{b, off}];
  endfunction

  // colour of one pixel of a 256x256 tile layer
  function automatic logic [31:0] layer_colour(input logic [12:0] map_off,
                                               input logic [7:0] lx, input logic [7:0] ly);
    logic [12:0] entry, data_off;
    logic [7:0]  tile, attr, lo, hi, tile_s;
    logic [2:0]  row, col, bitpos;
    logic [1:0]  cid;
    logic [5:0]  idx;
    logic [15:0] rgb;
    entry = map_off + 13'(ly[7:3]) * 13'd32 + 13'(lx[7:3]);
    tile = vram_byte(1'b0, entry);
    attr = cgb ? vram_byte(1'b1, entry) : 8'h00;
    tile_s = tile ^ 8'h80;
    data_off = lcdc[4] ? 13'(tile) * 13'd16 : 13'h0800 + 13'(tile_s) * 13'd16;
    row = attr[6] ? 3'd7 - ly[2:0] : ly[2:0];
    col = lx[2:0];
    bitpos = attr[5] ? col : 3'd7 - col;
    lo = vram_byte(attr[3], data_off + 13'(row) * 13'd2);
    hi = vram_byte(attr[3], data_off + 13'(row) * 13'd2 + 13'd1);
    cid = {hi[bitpos], lo[bitpos]};
    if (!cgb) return shade_of(bgp[2*cid +: 2]);
    idx = {attr[2:0], 3'b000} + {3'b000, cid, 1'b0};
    rgb = {pal_shadow[idx + 6'd1], pal_shadow[idx]};
    return {8'hFF, rgb[4:0], 3'b000, rgb[9:5], 3'b000, rgb[14:10], 3'b000};
  endfunction

  function automatic out_res_t render_pixel(input logic [7:0] px, input logic [7:0] py);
    out_res_t r;
    int       win_left;
    r = '0;
    r.out_x = px;
    r.out_y = py;
    win_left = int'(wx) - 7;
    if (lcdc[7]) begin
      r.drawn = 1'b1;
      if (lcdc[5] && wx <= 8'd166 && wy <= 8'd143 && py >= wy && int'(px) >= win_left) begin
        r.argb = layer_colour(lcdc[6] ? 13'h1C00 : 13'h1800, 8'(int'(px) - win_left),
                              py - wy);
        r.from_window = 1'b1;
      end else if (!lcdc[0] && !cgb) begin
        r.argb = shade_of(2'd0);
      end else begin
        r.argb = layer_colour(lcdc[3] ? 13'h1C00 : 13'h1800, px + scx, py + scy);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_res_t e;
    if (!rst_n) begin
      lcdc = 8'd145; scy = 8'd0; scx = 8'd0; wy = 8'd0; wx = 8'd0;
      bgp = 8'd252; cgb = 1'b0;
      pixel_q.delete();
      errors = 0;
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_LCDC: lcdc = cfg_pwdata[7:0];
          REG_SCY:  scy = cfg_pwdata[7:0];
          REG_SCX:  scx = cfg_pwdata[7:0];
          REG_WY:   wy = cfg_pwdata[7:0];
          REG_WX:   wx = cfg_pwdata[7:0];
          REG_BGP:  bgp = cfg_pwdata[7:0];
          REG_CGB:  cgb = cfg_pwdata[0];
          default: ;
        endcase
      end
      // compare a result against the oldest prediction
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected result x", 32'(out_data.out_x), 32'h0);
        end else begin
          e = pixel_q.pop_front();
          if (out_data.out_x !== e.out_x)
            report_mismatch("out_x", 32'(out_data.out_x), 32'(e.out_x));
          if (out_data.out_y !== e.out_y)
            report_mismatch("out_y", 32'(out_data.out_y), 32'(e.out_y));
          if (out_data.argb !== e.argb) report_mismatch("argb", out_data.argb, e.argb);
          if (out_data.drawn !== e.drawn)
            report_mismatch("drawn", 32'(out_data.drawn), 32'(e.drawn));
          if (out_data.from_window !== e.from_window)
            report_mismatch("from_window", 32'(out_data.from_window), 32'(e.from_window));
        end
      end
      // apply an accepted request
      if (in_valid && in_ready) begin
        case (in_data.op)
          OP_VRAM_WR: vram_shadow[{(VIDEO_BANKS > 1) ? in_data.addr[13] : 1'b0,
                                   in_data.addr[12:0]}] = in_data.wdata;
          OP_PAL_WR:  pal_shadow[in_data.addr[5:0]] = in_data.wdata;
          OP_RENDER:  pixel_q.push_back(render_pixel(in_data.pixel_x, in_data.pixel_y));
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/tb_tile_background_window_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_background_window_pixel_unit
// Loads both memories, then renders pixels under a series of register
// settings with random request and result stalls; the checker judges results.
// ----------------------------------------------------------------------------
module tb_tile_background_window_pixel_unit;
  import tbw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_req_t     in_data;
  out_res_t    out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          errors, pending;
  bit          quiet, gaps_on;
  int          stall_left;

  tile_background_window_pixel_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tile_background_window_pixel_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stall bursts unless in the quiet tail
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hold the request until taken
  task automatic send_req(input in_req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [1:0] op, input logic [13:0] addr,
                         input logic [7:0] wdata, input logic [7:0] px, input logic [7:0] py);
    in_req_t r;
    r.op = op; r.addr = addr; r.wdata = wdata; r.pixel_x = px; r.pixel_y = py;
    send_req(r);
  endtask

  // write one register over the cfg_ APB port
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] l, input logic [7:0] sy, input logic [7:0] sx,
                          input logic [7:0] y, input logic [7:0] x, input logic [7:0] p,
                          input logic c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(REG_LCDC, l);
    write_reg(REG_SCY, sy);
    write_reg(REG_SCX, sx);
    write_reg(REG_WY, y);
    write_reg(REG_WX, x);
    write_reg(REG_BGP, p);
    write_reg(REG_CGB, c);
  endtask

  // corner pixels, an unused op, then a random mix
  task automatic run_phase(input int n);
    int k;
    send_op(OP_RENDER, 14'h0, 8'h0, 8'd0, 8'd0);
    send_op(OP_RENDER, 14'h3FFF, 8'hFF, 8'd159, 8'd143);
    send_op(OP_RENDER, 14'h0, 8'h0, 8'd255, 8'd255);
    send_op(OP_UNUSED, 14'h3FFF, 8'hA5, 8'd80, 8'd72);
    send_op(OP_RENDER, 14'h1555, 8'h5A, 8'd80, 8'd72);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 60)
        send_op(OP_RENDER, 14'($urandom), 8'($urandom),
                $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 159)),
                $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 143)));
      else if (k < 88)
        send_op(OP_VRAM_WR, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (k < 97)
        send_op(OP_PAL_WR, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_op(OP_UNUSED, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    quiet = 1'b0;
    gaps_on = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both memories so no render reads an unwritten byte
    for (int a = 0; a < 16384; a++)
      send_op(OP_VRAM_WR, 14'(a), 8'($urandom), 8'($urandom), 8'($urandom));
    for (int a = 0; a < 64; a++)
      send_op(OP_PAL_WR, 14'(a) | 14'($urandom_range(0, 255) << 6), 8'($urandom),
              8'($urandom), 8'($urandom));
    gaps_on = 1'b1;

    set_regs(8'd145, 8'd0, 8'd0, 8'd0, 8'd0, 8'd252, 1'b0);
    run_phase(60);
    set_regs(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    run_phase(30);
    set_regs(8'hFF, 8'd255, 8'd255, 8'd0, 8'd0, 8'h1B, 1'b0);
    run_phase(60);
    set_regs(8'hE0, 8'd17, 8'd200, 8'd143, 8'd166, 8'hE4, 1'b0);
    run_phase(60);
    set_regs(8'hF9, 8'd3, 8'd9, 8'd70, 8'd7, 8'hFF, 1'b1);
    run_phase(70);
    set_regs(8'hE8, 8'd128, 8'd64, 8'd144, 8'd167, 8'h55, 1'b1);
    run_phase(60);
    set_regs(8'hA1, 8'd90, 8'd33, 8'd20, 8'd200, 8'hAA, 1'b0);
    run_phase(60);
    set_regs(8'hF6, 8'd255, 8'd1, 8'd255, 8'd255, 8'h27, 1'b1);
    run_phase(60);
    for (int p = 0; p < 3; p++) begin
      set_regs(8'($urandom) | 8'h80, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 150)),
               8'($urandom_range(0, 170)), 8'($urandom), 1'($urandom));
      if (p == 2) quiet = 1'b1;
      run_phase(70);
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (12) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
